// ===== rtl/core/fit_block_allocator_defines.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FAB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FAB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/fab_pkg.sv =====
package fab_pkg;

  localparam int SIZE_W = 16;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_ALLOC   = 2'd1;
  localparam logic [1:0] OP_RESTORE = 2'd2;

  // Placement policies. Code 3 acts as first fit.
  localparam logic [1:0] FIT_BEST  = 2'd0;
  localparam logic [1:0] FIT_WORST = 2'd1;
  localparam logic [1:0] FIT_FIRST = 2'd2;

  // Register select bit of the configuration address.
  localparam logic REG_FIT_MODE    = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  localparam logic [1:0] FIT_MODE_RST    = 2'd0;
  localparam logic [4:0] BLOCK_COUNT_RST = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } fab_state_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RESTORE,
    CMD_TAKE
  } fab_cmd_op_t;

  // Search token that walks down the row of cells.
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [SIZE_W-1:0] pick_size;
    logic [SIZE_W-1:0] request;
  } fab_tok_t;

  // Table update broadcast to every cell.
  typedef struct packed {
    fab_cmd_op_t       op;
    logic [SIZE_W-1:0] value;
  } fab_cmd_t;

endpackage

// ===== rtl/core/fit_block_allocator.sv =====
// Memory placement allocator: holds the free and loaded sizes of BLOCKS memory blocks, one
// block per cell in a row of cells, and places allocate requests by best, worst or first fit
// (fit_mode), searching the first block_count blocks with ties going to the lowest index.
// A load or restore beat yields no result. An allocate beat sends its search token
// down the whole row, one cell per cycle; the pick is then captured in a hold register,
// and once the output register is free the chosen block is written back and the result
// register is loaded. The input stalls while an allocate is in flight; a finished result
// waits in the output register without holding up the next beat. Block sizes read as
// undefined until loaded, so every searched or restored block must be loaded first.
`include "fit_block_allocator_defines.svh"

module fit_block_allocator #(
  parameter int BLOCKS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [3:0]  in_block_index,
  input  logic [15:0] in_size_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_granted,
  output logic [3:0]  out_chosen_block,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fab_pkg::*;

  localparam int IDXW = $clog2(BLOCKS);

  fab_state_t        state_r;
  fab_state_t        state_nxt;
  logic [1:0]        fit_mode_r;
  logic [4:0]        block_count_r;
  logic              accept;
  logic              idx_ok;
  logic              slot_free;
  logic              out_load;
  logic              hold_found_r;
  logic [IDXW-1:0]   hold_pick_r;
  logic [SIZE_W-1:0] hold_req_r;
  logic              out_valid_r;
  logic              out_granted_r;
  logic [3:0]        out_chosen_block_r;
  fab_cmd_t          cmd;
  logic [IDXW-1:0]   cmd_idx;
  fab_tok_t          tok  [BLOCKS+1];
  logic [IDXW-1:0]   pick [BLOCKS+1];
  logic [BLOCKS-1:0] use_vec;
  logic [BLOCKS-1:0] tok_valid_vec;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r    <= FIT_MODE_RST;
      block_count_r <= BLOCK_COUNT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_FIT_MODE:    fit_mode_r    <= pwdata[1:0];
        REG_BLOCK_COUNT: block_count_r <= pwdata[4:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FIT_MODE:    prdata = {30'd0, fit_mode_r};
      REG_BLOCK_COUNT: prdata = {27'd0, block_count_r};
    endcase
  end

  // Row of cells.
  assign accept = in_valid && !in_stall;
  assign idx_ok = (32'(in_block_index) < BLOCKS);

  always_comb begin
    tok[0].valid     = accept && (in_operation == OP_ALLOC);
    tok[0].found     = 1'b0;
    tok[0].pick_size = '0;
    tok[0].request   = in_size_value;
    pick[0]          = '0;
  end

  for (genvar g = 0; g < BLOCKS; g++) begin : g_cell
    // A block count above BLOCKS simply enables every cell.
    assign use_vec[g]       = (32'(block_count_r) > g);
    assign tok_valid_vec[g] = tok[g+1].valid;

    fab_cell #(
      .BLOCKS (BLOCKS),
      .INDEX  (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_use   (use_vec[g]),
      .fit_mode (fit_mode_r),
      .cmd      (cmd),
      .cmd_idx  (cmd_idx),
      .tok_in   (tok[g]),
      .pick_in  (pick[g]),
      .tok_out  (tok[g+1]),
      .pick_out (pick[g+1])
    );
  end

  // Sequencer.
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_operation == OP_ALLOC)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok[BLOCKS].valid) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    out_load  = 1'b0;
    cmd.op    = CMD_NONE;
    cmd.value = in_size_value;
    cmd_idx   = IDXW'(in_block_index);
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && (in_operation == OP_LOAD) && idx_ok) begin
          cmd.op = CMD_LOAD;
        end else if (in_valid && (in_operation == OP_RESTORE)) begin
          cmd.op = CMD_RESTORE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_load  = 1'b1;
          cmd.value = hold_req_r;
          cmd_idx   = hold_pick_r;
          if (hold_found_r) begin
            cmd.op = CMD_TAKE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_SCAN) && tok[BLOCKS].valid) begin
      hold_found_r <= tok[BLOCKS].found;
      hold_pick_r  <= pick[BLOCKS];
      hold_req_r   <= tok[BLOCKS].request;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_granted_r      <= hold_found_r;
      out_chosen_block_r <= hold_found_r ? 4'(hold_pick_r) : 4'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted      = out_granted_r;
  assign out_chosen_block = out_chosen_block_r;

  `FAB_ASSERT_SAME(a_single_token, 1'b1, $countones(tok_valid_vec) <= 1, "more than one search token in the row")
  `FAB_ASSERT_SAME(a_tail_in_scan, tok[BLOCKS].valid, state_r == ST_SCAN, "search token left the row outside a scan")
  `FAB_ASSERT_NEXT(a_alloc_scans, accept && (in_operation == OP_ALLOC), state_r == ST_SCAN, "allocate beat did not start a scan")
  `FAB_ASSERT_SAME(a_denied_zero, out_valid_r && !out_granted_r, out_chosen_block_r == 4'd0, "denied result carries a block index")

endmodule

// ===== rtl/core/fab_cell.sv =====
module fab_cell #(
  parameter int BLOCKS = 16,
  parameter int INDEX  = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_use,
  input  logic [1:0]                    fit_mode,
  input  fab_pkg::fab_cmd_t             cmd,
  input  logic [$clog2(BLOCKS)-1:0]     cmd_idx,
  input  fab_pkg::fab_tok_t             tok_in,
  input  logic [$clog2(BLOCKS)-1:0]     pick_in,
  output fab_pkg::fab_tok_t             tok_out,
  output logic [$clog2(BLOCKS)-1:0]     pick_out
);
  import fab_pkg::*;

  localparam int IDXW = $clog2(BLOCKS);

  logic [SIZE_W-1:0] free_r;
  logic [SIZE_W-1:0] loaded_r;
  logic              tok_valid_r;
  fab_tok_t          tok_r;
  fab_tok_t          tok_nxt;
  logic [IDXW-1:0]   pick_r;
  logic [IDXW-1:0]   pick_nxt;
  logic              mine;
  logic              fits;
  logic              take;

  assign mine = (cmd_idx == IDXW'(INDEX));

  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        if (mine) begin
          free_r   <= cmd.value;
          loaded_r <= cmd.value;
        end
      end
      CMD_RESTORE: begin
        if (in_use) begin
          free_r <= loaded_r;
        end
      end
      CMD_TAKE: begin
        if (mine) begin
          free_r <= free_r - cmd.value;
        end
      end
      default: begin
      end
    endcase
  end

  // Strict compares keep ties on the lower index, which the token saw first.
  always_comb begin
    fits = tok_in.valid && in_use && (free_r >= tok_in.request);
    take = 1'b0;
    if (fits) begin
      if (!tok_in.found) begin
        take = 1'b1;
      end else if (fit_mode == FIT_BEST) begin
        take = (free_r < tok_in.pick_size);
      end else if (fit_mode == FIT_WORST) begin
        take = (free_r > tok_in.pick_size);
      end
    end
    tok_nxt  = tok_in;
    pick_nxt = pick_in;
    if (take) begin
      tok_nxt.found     = 1'b1;
      tok_nxt.pick_size = free_r;
      pick_nxt          = IDXW'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_r  <= tok_nxt;
    pick_r <= pick_nxt;
  end

  always_comb begin
    tok_out       = tok_r;
    tok_out.valid = tok_valid_r;
  end

  assign pick_out = pick_r;

endmodule
